FILE: hdl/prefix_code_tree_decoder_defines.svh
// prefix_code_tree_decoder_defines.svh
// Assertion macros for the prefix-code tree decoder RTL; no dependencies.
`ifndef PREFIX_CODE_TREE_DECODER_DEFINES_SVH
`define PREFIX_CODE_TREE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PCTD_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error("%m: assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define PCTD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define PCTD_ASSERT(lbl, clk_i, rstn_i, prop)
`define PCTD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

FILE: hdl/pctd_pkg.sv
// pctd_pkg.sv
// Shared constants, codes and controller/datapath interface types of the
// prefix-code tree decoder. No dependencies.
package pctd_pkg;

	localparam int NODE_DEPTH    = 512;
	localparam int MAX_CODE_BITS = 32;

	localparam int IDX_W   = $clog2(NODE_DEPTH);
	localparam int USED_W  = $clog2(NODE_DEPTH + 1);
	localparam int CNT_W   = $clog2(MAX_CODE_BITS + 1);
	localparam int SYM_W   = 8;
	localparam int LEN_W   = 6;
	localparam int CODE_W  = 32;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 32;
	localparam int STAT_W  = 3;

	typedef enum logic [1:0] {
		FN_START  = 2'd0,
		FN_ADD    = 2'd1,
		FN_DECODE = 2'd2,
		FN_NOP    = 2'd3
	} func_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_CONFLICT  = 3'd2,
		ST_MISSING   = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_e_t;

	typedef enum logic [1:0] {
		RD_NODE,
		RD_WALK,
		RD_CHILD
	} rd_sel_t;

	typedef enum logic [1:0] {
		WALK_HOLD,
		WALK_ROOT,
		WALK_NODE
	} walk_sel_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_PEND,
		EMIT_STATQ
	} emit_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RESP,
		S_ADD_RD,
		S_ADD_EVAL,
		S_ADD_LINK,
		S_DEC_RD,
		S_DEC_EVAL,
		S_DEC_LEAF,
		S_DEC_END,
		S_DEC_MISS
	} state_t;

	// One node of the decode tree; a child index of zero means no child.
	typedef struct packed {
		logic                      leaf;
		logic [SYM_W-1:0]          sym;
		logic [1:0][IDX_W-1:0]     child;
	} node_t;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       set_stat;
		status_e_t  stat_val;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       node_child;
		logic       step;
		logic       wr_new;
		logic       wr_link;
		walk_sel_t  walk_sel;
		logic       sym_dec;
		logic       pend_load;
		logic       pend_clear;
		emit_src_t  emit_src;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		func_e_t func;
		logic    cnt_zero;
		logic    final_bit;
		logic    leaf;
		logic    child_zero;
		logic    full;
		logic    sym_zero;
		logic    sym_one;
		logic    pend_valid;
		logic    out_free;
	} sts_t;

endpackage

FILE: hdl/pctd_ctrl.sv
// pctd_ctrl.sv
// Sequencer of the prefix-code tree decoder: walks insert and decode steps.
// Depends on pctd_pkg and prefix_code_tree_decoder_defines.svh.
`include "prefix_code_tree_decoder_defines.svh"

module pctd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output pctd_pkg::cmd_t cmd,
	input  pctd_pkg::sts_t sts
);
	import pctd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (sts.func)
					FN_ADD:    state_nxt = sts.cnt_zero ? S_RESP : S_ADD_RD;
					FN_DECODE: state_nxt = sts.sym_zero ? S_RESP : S_DEC_RD;
					default:   state_nxt = S_RESP;
				endcase
			end
			S_RESP: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			S_ADD_RD: state_nxt = S_ADD_EVAL;
			S_ADD_EVAL: begin
				if (sts.leaf) state_nxt = S_RESP;
				else if (!sts.child_zero) state_nxt = sts.final_bit ? S_RESP : S_ADD_RD;
				else if (sts.full) state_nxt = S_RESP;
				else state_nxt = S_ADD_LINK;
			end
			S_ADD_LINK: state_nxt = sts.final_bit ? S_RESP : S_ADD_RD;
			S_DEC_RD: state_nxt = S_DEC_EVAL;
			S_DEC_EVAL: state_nxt = sts.child_zero ? S_DEC_MISS : S_DEC_LEAF;
			S_DEC_LEAF: begin
				if (sts.leaf) begin
					if (!(sts.pend_valid && !sts.out_free)) begin
						state_nxt = (sts.sym_one || sts.final_bit) ? S_DEC_END : S_DEC_RD;
					end
				end else begin
					state_nxt = sts.final_bit ? S_DEC_END : S_DEC_RD;
				end
			end
			S_DEC_END: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			S_DEC_MISS: begin
				if (sts.out_free && !sts.pend_valid) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DISPATCH: begin
				case (sts.func)
					FN_START: begin
						cmd.clear    = 1'b1;
						cmd.set_stat = 1'b1;
						cmd.stat_val = ST_OK;
					end
					FN_ADD: begin
						cmd.set_stat = sts.cnt_zero;
						cmd.stat_val = ST_OK;
					end
					FN_DECODE: begin
						cmd.set_stat = sts.sym_zero;
						cmd.stat_val = ST_EXHAUSTED;
					end
					default: begin
						cmd.set_stat = 1'b1;
						cmd.stat_val = ST_OK;
					end
				endcase
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit_src  = EMIT_STATQ;
					cmd.emit_last = 1'b1;
				end
			end
			S_ADD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NODE;
			end
			S_ADD_EVAL: begin
				if (sts.leaf) begin
					cmd.set_stat = 1'b1;
					cmd.stat_val = ST_CONFLICT;
				end else if (!sts.child_zero) begin
					if (sts.final_bit) begin
						cmd.set_stat = 1'b1;
						cmd.stat_val = ST_CONFLICT;
					end else begin
						cmd.node_child = 1'b1;
						cmd.step       = 1'b1;
					end
				end else if (sts.full) begin
					cmd.set_stat = 1'b1;
					cmd.stat_val = ST_FULL;
				end else begin
					cmd.wr_new = 1'b1;
				end
			end
			S_ADD_LINK: begin
				cmd.wr_link  = 1'b1;
				cmd.step     = 1'b1;
				cmd.set_stat = sts.final_bit;
				cmd.stat_val = ST_OK;
			end
			S_DEC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_WALK;
			end
			S_DEC_EVAL: begin
				if (sts.child_zero) begin
					cmd.walk_sel = WALK_ROOT;
					cmd.set_stat = 1'b1;
					cmd.stat_val = ST_MISSING;
				end else begin
					cmd.rd_en      = 1'b1;
					cmd.rd_sel     = RD_CHILD;
					cmd.node_child = 1'b1;
				end
			end
			S_DEC_LEAF: begin
				if (sts.leaf) begin
					if (!(sts.pend_valid && !sts.out_free)) begin
						if (sts.pend_valid) cmd.emit_src = EMIT_PEND;
						cmd.pend_load = 1'b1;
						cmd.walk_sel  = WALK_ROOT;
						cmd.sym_dec   = 1'b1;
						cmd.step      = 1'b1;
						cmd.set_stat  = sts.sym_one || sts.final_bit;
						cmd.stat_val  = ST_OK;
					end
				end else begin
					cmd.walk_sel = WALK_NODE;
					cmd.step     = 1'b1;
					cmd.set_stat = sts.final_bit;
					cmd.stat_val = ST_OK;
				end
			end
			S_DEC_END: begin
				if (sts.out_free) begin
					cmd.emit_src   = sts.pend_valid ? EMIT_PEND : EMIT_STATQ;
					cmd.emit_last  = 1'b1;
					cmd.pend_clear = sts.pend_valid;
				end
			end
			S_DEC_MISS: begin
				if (sts.out_free) begin
					cmd.emit_src   = sts.pend_valid ? EMIT_PEND : EMIT_STATQ;
					cmd.emit_last  = !sts.pend_valid;
					cmd.pend_clear = sts.pend_valid;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`PCTD_ASSERT_NXT(a_load_dispatch, clk, arst_n, in_valid && !in_stall, state_q == S_DISPATCH)
	`PCTD_ASSERT(a_emit_free, clk, arst_n, (cmd.emit_src != EMIT_NONE) |-> sts.out_free)
	`PCTD_ASSERT_NXT(a_new_then_link, clk, arst_n, cmd.wr_new, cmd.wr_link)

endmodule

FILE: hdl/pctd_dpath.sv
// pctd_dpath.sv
// Datapath of the prefix-code tree decoder: node store, walk and insert
// registers, pending symbol and output register. Depends on pctd_pkg and
// prefix_code_tree_decoder_defines.svh.
`include "prefix_code_tree_decoder_defines.svh"

module pctd_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pctd_pkg::COUNT_W-1:0]  cfg_wr_data,
	input  logic [1:0]                    func,
	input  logic [pctd_pkg::SYM_W-1:0]    symbol,
	input  logic [pctd_pkg::LEN_W-1:0]    code_length,
	input  logic [pctd_pkg::CODE_W-1:0]   code_bits,
	input  logic [pctd_pkg::DATA_W-1:0]   data_byte,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [pctd_pkg::SYM_W-1:0]    out_symbol,
	output logic                          has_symbol,
	output logic [pctd_pkg::STAT_W-1:0]   status,
	output logic                          last,
	input  pctd_pkg::cmd_t                cmd,
	output pctd_pkg::sts_t                sts
);
	import pctd_pkg::*;

	localparam int NODE_W = $bits(node_t);

	// Node store; entry 0 (the root) lives in flops so reset and start
	// can clear it at once.
	logic [NODE_W-1:0]          mem [NODE_DEPTH];
	logic [NODE_W-1:0]          rdata_q;
	logic                       rd_root_q;
	logic [1:0][IDX_W-1:0]      root_child_q;

	logic [COUNT_W-1:0]         output_count_q;
	logic [COUNT_W-1:0]         symbols_left_q;
	logic [USED_W-1:0]          nodes_used_q;
	logic [IDX_W-1:0]           walk_q;
	logic [IDX_W-1:0]           node_q;
	logic [IDX_W-1:0]           new_q;
	func_e_t                    func_q;
	logic [SYM_W-1:0]           sym_q;
	logic [CODE_W-1:0]          bits_q;
	logic [CNT_W-1:0]           cnt_q;
	status_e_t                  stat_q;
	logic                       pend_valid_q;
	logic [SYM_W-1:0]           pend_sym_q;

	logic                       out_valid_q;
	logic [SYM_W-1:0]           out_symbol_q;
	logic                       has_symbol_q;
	status_e_t                  status_q;
	logic                       last_q;

	node_t                      node_rd;
	node_t                      link_node;
	node_t                      new_node;
	logic                       cur_bit;
	logic [IDX_W-1:0]           child_idx;
	logic [IDX_W-1:0]           rd_addr;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [NODE_W-1:0]          mem_wdata;
	logic [CNT_W-1:0]           len_sat;
	logic                       final_bit;
	logic                       out_free;
	logic                       emit;

	assign node_rd   = rd_root_q ? node_t'{leaf: 1'b0, sym: '0, child: root_child_q}
	                             : node_t'(rdata_q);
	assign cur_bit   = bits_q[0];
	assign child_idx = node_rd.child[cur_bit];
	assign final_bit = (cnt_q == CNT_W'(1));
	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = (cmd.emit_src != EMIT_NONE);
	assign len_sat   = (int'(code_length) > MAX_CODE_BITS) ? CNT_W'(MAX_CODE_BITS)
	                                                        : CNT_W'(code_length);

	always_comb begin
		case (cmd.rd_sel)
			RD_NODE:  rd_addr = node_q;
			RD_WALK:  rd_addr = walk_q;
			RD_CHILD: rd_addr = child_idx;
			default:  rd_addr = node_q;
		endcase
	end

	always_comb begin
		new_node          = '0;
		new_node.leaf     = final_bit;
		new_node.sym      = final_bit ? sym_q : '0;
		link_node         = node_rd;
		link_node.child[cur_bit] = new_q;
		mem_we    = cmd.wr_new || (cmd.wr_link && (node_q != '0));
		mem_waddr = cmd.wr_new ? nodes_used_q[IDX_W-1:0] : node_q;
		mem_wdata = cmd.wr_new ? NODE_W'(new_node) : NODE_W'(link_node);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd_en) begin
			rdata_q   <= mem[rd_addr];
			rd_root_q <= (rd_addr == '0);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_count_q <= '0;
			symbols_left_q <= '0;
			nodes_used_q   <= USED_W'(1);
			walk_q         <= '0;
			root_child_q   <= '0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) output_count_q <= cfg_wr_data;
			if (cmd.clear) begin
				symbols_left_q <= output_count_q;
				nodes_used_q   <= USED_W'(1);
				root_child_q   <= '0;
			end else begin
				if (cmd.sym_dec) symbols_left_q <= symbols_left_q - COUNT_W'(1);
				if (cmd.wr_new) nodes_used_q <= nodes_used_q + USED_W'(1);
				if (cmd.wr_link && (node_q == '0)) root_child_q[cur_bit] <= new_q;
			end
			if (cmd.clear) begin
				walk_q <= '0;
			end else begin
				case (cmd.walk_sel)
					WALK_ROOT: walk_q <= '0;
					WALK_NODE: walk_q <= node_q;
					default:   walk_q <= walk_q;
				endcase
			end
			if (cmd.pend_load) pend_valid_q <= 1'b1;
			else if (cmd.pend_clear) pend_valid_q <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Item and walk payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_e_t'(func);
			sym_q  <= symbol;
			node_q <= '0;
			if (func_e_t'(func) == FN_ADD) begin
				bits_q <= code_bits;
				cnt_q  <= len_sat;
			end else begin
				bits_q <= CODE_W'(data_byte);
				cnt_q  <= CNT_W'(DATA_W);
			end
		end else begin
			if (cmd.node_child) node_q <= child_idx;
			else if (cmd.wr_link) node_q <= new_q;
			if (cmd.step) begin
				bits_q <= {1'b0, bits_q[CODE_W-1:1]};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
		end
		if (cmd.wr_new) new_q <= nodes_used_q[IDX_W-1:0];
		if (cmd.set_stat) stat_q <= cmd.stat_val;
		if (cmd.pend_load) pend_sym_q <= node_rd.sym;
		if (emit) begin
			last_q <= cmd.emit_last;
			if (cmd.emit_src == EMIT_PEND) begin
				out_symbol_q <= pend_sym_q;
				has_symbol_q <= 1'b1;
				status_q     <= ST_OK;
			end else begin
				out_symbol_q <= '0;
				has_symbol_q <= 1'b0;
				status_q     <= stat_q;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.func       = func_q;
		sts.cnt_zero   = (cnt_q == '0);
		sts.final_bit  = final_bit;
		sts.leaf       = node_rd.leaf;
		sts.child_zero = (child_idx == '0);
		sts.full       = (nodes_used_q == USED_W'(NODE_DEPTH));
		sts.sym_zero   = (symbols_left_q == '0);
		sts.sym_one    = (symbols_left_q == COUNT_W'(1));
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_symbol_q;
	assign has_symbol = has_symbol_q;
	assign status     = status_q;
	assign last       = last_q;

	`PCTD_ASSERT(a_used_range, clk, arst_n, (nodes_used_q != '0) && (int'(nodes_used_q) <= NODE_DEPTH))
	`PCTD_ASSERT(a_alloc_room, clk, arst_n, cmd.wr_new |-> (int'(nodes_used_q) < NODE_DEPTH))
	`PCTD_ASSERT(a_pend_emit, clk, arst_n, (cmd.emit_src == EMIT_PEND) |-> pend_valid_q)

endmodule

FILE: hdl/prefix_code_tree_decoder.sv
// prefix_code_tree_decoder.sv
// Top level of the prefix-code tree decoder: joins sequencer and datapath.
// Depends on pctd_pkg, pctd_ctrl and pctd_dpath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer:
//   start (clear tree, load the symbol count), add one code, or decode one
//   data byte. Output channel (out_valid/out_stall) carries result items;
//   the last result of a command has last set. output_count is written via
//   cfg_wr_en/cfg_wr_data and is sampled by start; the user must write it
//   only while the block is idle (the block does not enforce this). Start
//   and unused commands go from dispatch to the response state. An add
//   reads and evaluates the current node per code bit, plus a link step
//   per bit that creates a node. A decode byte reads the walk node, checks
//   its child and classifies that child per bit, then ends; the next
//   command can transfer in the cycle after its last result. The pace is
//   set by the single node-store read port: each code bit needs a read of
//   the current node, and each decode bit a second read of the child to
//   classify it as leaf or branch. Each decoded symbol is held back one
//   step so that the final one can carry last. in_stall is low only while
//   no command is in progress; the output register lets a new command be
//   taken while a result waits. When the receiver stalls, hold the result
//   and pause the walk. Reset empties the tree to a lone root, zeroes the
//   count and drops output valid; no clearing pass is needed.

module prefix_code_tree_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pctd_pkg::COUNT_W-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [pctd_pkg::SYM_W-1:0]    symbol,
	input  logic [pctd_pkg::LEN_W-1:0]    code_length,
	input  logic [pctd_pkg::CODE_W-1:0]   code_bits,
	input  logic [pctd_pkg::DATA_W-1:0]   data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pctd_pkg::SYM_W-1:0]    out_symbol,
	output logic                          has_symbol,
	output logic [pctd_pkg::STAT_W-1:0]   status,
	output logic                          last
);
	import pctd_pkg::*;

	// Command and status bundles between sequencer and datapath.
	cmd_t cmd;
	sts_t sts;

	pctd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	pctd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.func        (func),
		.symbol      (symbol),
		.code_length (code_length),
		.code_bits   (code_bits),
		.data_byte   (data_byte),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_symbol  (out_symbol),
		.has_symbol  (has_symbol),
		.status      (status),
		.last        (last),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
